@@ src/krt_pkg.sv @@
// shared types, codes and name cleanup for the keyed record table
package krt_pkg;

   localparam int TableDepthDefault = 16;
   localparam int NameBits          = 256;
   localparam int NameKeep          = 31;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SELECT = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_DELETE = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [31:0]         key;
      logic [NameBits-1:0] name;
      logic [63:0]         score;
   } record_type;

   // keep bytes up to the first zero byte, clear the rest and the last byte
   function automatic logic [NameBits-1:0] clean_name(input logic [NameBits-1:0] raw);
      logic [NameBits-1:0] res;
      logic                keep;
      res  = '0;
      keep = 1'b1;
      for (int b = 0; b < NameKeep; b++) begin
         keep = keep & (raw[b*8 +: 8] != 8'd0);
         if (keep) begin
            res[b*8 +: 8] = raw[b*8 +: 8];
         end
      end
      return res;
   endfunction

endpackage

@@ src/krt_cell.sv @@
// one record slot of the rotating table ring
module krt_cell
   import krt_pkg::*;
(
   input  logic       clock,
   input  logic       shift,
   input  logic       load,
   input  record_type neighbor_in,
   input  record_type load_data,
   output record_type rec_out
);

   record_type rec_ff;
   record_type rec_in;

   // a load replaces the word coming around from the head
   assign rec_in  = load ? load_data : neighbor_in;
   assign rec_out = rec_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         rec_ff <= rec_in;
      end
   end

endmodule

@@ src/keyed_record_table.sv @@
// top level: keyed record table built as a rotating ring of record cells
//
// The records sit in a ring of TABLE_DEPTH cells that rotates by one slot per
// cycle while an operation runs and the ring is not held; the key is compared
// at the head cell only. Insert, select, update and a delete of an absent key
// take one full turn of the ring, and req_stall holds off a new request until
// the operation ends. A delete that finds its key needs a second turn to drop
// the last record into the freed slot. A request can be taken while the
// previous response still waits on rsp_stall; the ring holds on its last step
// until the response register is free.
module keyed_record_table
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_key,
   input  logic [63:0]        req_name_word_0,
   input  logic [63:0]        req_name_word_1,
   input  logic [63:0]        req_name_word_2,
   input  logic [63:0]        req_name_word_3,
   input  logic [63:0]        req_score_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_found_name_0,
   output logic [63:0]        rsp_found_name_1,
   output logic [63:0]        rsp_found_name_2,
   output logic [63:0]        rsp_found_name_3,
   output logic [63:0]        rsp_found_score,
   output logic [4:0]         rsp_entry_count
);

   localparam int SW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [SW-1:0] LastStep = SW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PASS1 = 2'd1;
   localparam logic [1:0] S_PASS2 = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [1:0]          op_ff;
   logic [31:0]         key_ff;
   logic [NameBits-1:0] name_ff;
   logic [63:0]         score_ff;
   record_type          cap_ff, cap_in;
   record_type          last_ff, last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [NameBits-1:0] out_name_ff, out_name_in;
   logic [63:0]         out_score_ff, out_score_in;

   record_type          ring [TABLE_DEPTH];
   record_type          head;
   record_type          wdata;
   logic                wr;

   logic accept, busy, last, live, hit, found_now, finish, out_free, advance;

   assign busy     = (state_ff != S_IDLE);
   assign req_stall = busy;
   assign accept   = req_valid && !busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign head     = ring[0];
   assign last     = (step_ff == LastStep);
   assign live     = (CW'(step_ff) < count_ff);
   assign hit      = (state_ff == S_PASS1) && live && !found_ff && (head.key == key_ff);
   assign found_now = found_ff || hit;

   always_comb begin
      finish = 1'b0;
      if (last) begin
         if (state_ff == S_PASS2) begin
            finish = 1'b1;
         end else if (state_ff == S_PASS1) begin
            finish = !((op_ff == OP_DELETE) && found_now);
         end
      end
   end

   // hold the ring on its last step while the response register is taken
   assign advance = busy && !(finish && !out_free);

   // word written into the tail as the head comes around
   always_comb begin
      wr    = 1'b0;
      wdata = '{key: key_ff, name: name_ff, score: score_ff};
      if (state_ff == S_PASS1) begin
         if (op_ff == OP_UPDATE && hit) begin
            wr         = 1'b1;
            wdata.key  = head.key;
         end else if (op_ff == OP_INSERT && !found_ff && CW'(step_ff) == count_ff) begin
            wr = 1'b1;
         end
      end else if (state_ff == S_PASS2 && step_ff == slot_ff) begin
         wr    = 1'b1;
         wdata = last_ff;
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      krt_cell u_cell (
         .clock       (clock),
         .shift       (advance),
         .load        ((i == TABLE_DEPTH - 1) && wr),
         .neighbor_in (ring[(i + 1) % TABLE_DEPTH]),
         .load_data   (wdata),
         .rec_out     (ring[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      cap_in       = cap_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      out_name_in  = out_name_ff;
      out_score_in = out_score_ff;

      if (accept) begin
         state_in = S_PASS1;
         step_in  = '0;
         found_in = 1'b0;
      end

      if (advance) begin
         step_in = last ? '0 : step_ff + 1'b1;
         if (state_ff == S_PASS1) begin
            if (hit) begin
               found_in = 1'b1;
               slot_in  = step_ff;
               cap_in   = head;
            end
            if (CW'(step_ff) + 1'b1 == count_ff) begin
               last_in = head;
            end
            if (last && !finish) begin
               state_in = S_PASS2;
            end
         end
      end

      if (finish && out_free) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         out_name_in  = '0;
         out_score_in = '0;
         case (op_ff)
            OP_INSERT: begin
               if (found_now) begin
                  status_in = ST_PRESENT;
               end else if (count_ff >= FullCount) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  count_in  = count_ff + 1'b1;
               end
            end
            OP_SELECT: begin
               status_in = found_now ? ST_DONE : ST_ABSENT;
               if (found_now) begin
                  out_name_in  = hit ? head.name : cap_ff.name;
                  out_score_in = hit ? head.score : cap_ff.score;
               end
            end
            OP_UPDATE: begin
               status_in = found_now ? ST_DONE : ST_ABSENT;
            end
            default: begin
               if (state_ff == S_PASS2) begin
                  status_in = ST_DONE;
                  count_in  = count_ff - 1'b1;
               end else begin
                  status_in = ST_ABSENT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      cap_ff       <= cap_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      out_name_ff  <= out_name_in;
      out_score_ff <= out_score_in;
      if (accept) begin
         op_ff    <= req_operation;
         key_ff   <= $unsigned(req_key);
         name_ff  <= clean_name({req_name_word_3, req_name_word_2,
                                 req_name_word_1, req_name_word_0});
         score_ff <= req_score_bits;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_name_0 = out_name_ff[63:0];
   assign rsp_found_name_1 = out_name_ff[127:64];
   assign rsp_found_name_2 = out_name_ff[191:128];
   assign rsp_found_name_3 = out_name_ff[255:192];
   assign rsp_found_score  = out_score_ff;
   assign rsp_entry_count  = 5'(count_ff);

endmodule

@@ src/krt_check.sv @@
// port-level checks for the keyed record table, bound to the top level
module krt_check
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
)
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic [63:0]        rsp_found_name_0,
   input logic [63:0]        rsp_found_name_1,
   input logic [63:0]        rsp_found_name_2,
   input logic [63:0]        rsp_found_name_3,
   input logic [63:0]        rsp_found_score,
   input logic [4:0]         rsp_entry_count
);

   localparam logic [4:0] FullCount = 5'(TABLE_DEPTH);

   // a taken request keeps the engine busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine not busy after a taken request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_found_score))
      else $error("stalled response word changed");

   // a full refusal only when the table really is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == FullCount)
      else $error("full status with room left");

   // found fields are zero on any response whose status is not done
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_found_score == 64'd0
         && rsp_found_name_0 == 64'd0 && rsp_found_name_1 == 64'd0
         && rsp_found_name_2 == 64'd0 && rsp_found_name_3 == 64'd0)
      else $error("found fields set on a failed operation");

   // the count moves by at most one from one operation to the next
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(rsp_entry_count) |->
         (rsp_entry_count == $past(rsp_entry_count) + 5'd1)
         || (rsp_entry_count == $past(rsp_entry_count) - 5'd1))
      else $error("entry count jumped by more than one");

endmodule

bind keyed_record_table krt_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_krt_check (.*);
